[design/assert_macros.svh]
// assertion macros shared by the rasterizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/blr_pkg.sv]
// types and constants of the line rasterizer
package blr_pkg;

    localparam int COORD_BITS = 6;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef struct packed {
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_line_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_pixel;
    } t_pixel;

    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic zero_len;
        logic last_step;
    } t_dp_status;

endpackage

[design/bresenham_line_rasterizer.sv]
// top level of the bresenham line rasterizer
//  channel  dir  valid        stall        payload
//  in       in   i_in_valid   o_in_stall   i_in_data  (t_line_req)
//  out      out  o_out_valid  i_out_stall  o_out_data (t_pixel)
// a request is taken, then the walk emits one pixel per cycle while the output is not stalled,
// so a line of major span n gives n pixels (up to 63), set by the step loop.
// a zero-length line is taken and gives no pixel.
// the next request is taken in the cycle after the last pixel is registered.
// a stalled output holds the walk; synchronous reset returns to idle.
module bresenham_line_rasterizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  blr_pkg::t_line_req i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output blr_pkg::t_pixel    o_out_data
);

    blr_pkg::t_dp_cmd    cmd;
    blr_pkg::t_dp_status status;

    blr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    blr_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

[design/blr_datapath.sv]
// line walk datapath: setup, error term, positions and pixel output register
`include "assert_macros.svh"

module blr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  blr_pkg::t_line_req  i_in_data,
    input  blr_pkg::t_dp_cmd    i_cmd,
    output blr_pkg::t_dp_status o_status,
    output blr_pkg::t_pixel     o_out_data
);

    localparam int CB = blr_pkg::COORD_BITS;

    blr_pkg::t_coord r_major, r_minor, r_steps;
    blr_pkg::t_err   r_err, r_inc_e, r_inc_d;
    logic            r_major_neg, r_minor_neg, r_steep;
    blr_pkg::t_pixel r_out;

    logic signed [CB:0] dx, dy, adx_full, ady_full;
    blr_pkg::t_coord    adx, ady, dmaj, dmin;
    logic               xneg, yneg, steep;

    always_comb begin
        dx = $signed({1'b0, i_in_data.x_end}) - $signed({1'b0, i_in_data.x_start});
        dy = $signed({1'b0, i_in_data.y_end}) - $signed({1'b0, i_in_data.y_start});
        // zero difference counts as a negative step
        xneg = (dx <= 0);
        yneg = (dy <= 0);
        adx_full = xneg ? -dx : dx;
        ady_full = yneg ? -dy : dy;
        adx = adx_full[CB-1:0];
        ady = ady_full[CB-1:0];
        steep = (ady > adx);
        dmaj = steep ? ady : adx;
        dmin = steep ? adx : ady;
    end

    assign o_status.zero_len  = (dmaj == '0);
    assign o_status.last_step = (r_steps == blr_pkg::t_coord'(1));
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steep     <= 1'b0;
            r_major     <= '0;
            r_minor     <= '0;
            r_major_neg <= 1'b0;
            r_minor_neg <= 1'b0;
            r_steps     <= '0;
            r_err       <= '0;
            r_inc_e     <= '0;
            r_inc_d     <= '0;
            r_out       <= '0;
        end else if (i_cmd.load) begin
            r_steep     <= steep;
            r_major     <= steep ? i_in_data.y_start : i_in_data.x_start;
            r_minor     <= steep ? i_in_data.x_start : i_in_data.y_start;
            r_major_neg <= steep ? yneg : xneg;
            r_minor_neg <= steep ? xneg : yneg;
            r_steps     <= dmaj;
            r_err       <= $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
            r_inc_e     <= $signed({2'b00, dmin, 1'b0});
            r_inc_d     <= $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
        end else if (i_cmd.step) begin
            r_out.pixel_x    <= r_steep ? r_minor : r_major;
            r_out.pixel_y    <= r_steep ? r_major : r_minor;
            r_out.last_pixel <= o_status.last_step;
            if (r_err <= 0) begin
                r_err <= r_err + r_inc_e;
            end else begin
                r_err   <= r_err + r_inc_d;
                r_minor <= r_minor_neg ? r_minor - 1'b1 : r_minor + 1'b1;
            end
            r_major <= r_major_neg ? r_major - 1'b1 : r_major + 1'b1;
            r_steps <= r_steps - 1'b1;
        end
    end

    // each pixel step consumes exactly one remaining step
    `ASSERT_NEXT(a_steps_count, i_clk, i_rst_n, i_cmd.step && !i_cmd.load,
                 r_steps == $past(r_steps) - 1'b1)

endmodule

[design/blr_ctrl.sv]
// controller: request intake, walk sequencing and output valid
`include "assert_macros.svh"

module blr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    input  blr_pkg::t_dp_status i_status,
    output blr_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step = (r_state == S_WALK) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load && !i_status.zero_len) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (o_cmd.step) begin
                    n_out_valid = 1'b1;
                    if (i_status.last_step) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a request with length starts a walk
    `ASSERT_NEXT(a_load_walk, i_clk, i_rst_n, o_cmd.load && !i_status.zero_len,
                 r_state == S_WALK)
    // the final pixel ends the walk with the pixel presented
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_cmd.step && i_status.last_step,
                 r_state == S_IDLE && r_out_valid)
    // a step never overwrites a pixel still waiting downstream
    `ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.step,
                !r_out_valid || !i_out_stall)

endmodule
